/* rtl/core/udov_pkg.sv */
// Shared types and constants of the unison dual-oscillator voice core.
// Used by udov_phase_store and unison_dual_osc_voice_core; depends on nothing.
package udov_pkg;

  localparam int MAX_VOICES_DEF = 8;

  localparam int PHASE_W   = 24;  // Q0.24 phase
  localparam int STEP_W    = 25;  // voice step, saturates at 2^25-1
  localparam int VOICE_W   = 28;  // signed per-voice value
  localparam int OUT_W     = 19;  // Q3.16 signed output
  localparam int CFG_W     = 17;  // widest register
  localparam int CFG_IDX_W = 3;
  localparam int DM_W      = 29;  // fm_depth times the 0.05 scale

  localparam logic [11:0] FM_SCALE = 12'd3277;  // 0.05 in Q0.16
  localparam logic [16:0] BLEND_ONE = 17'd65536;
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_TWO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OSC_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOICES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DETUNE    = 3'd4;

  // Register reset values
  localparam logic [16:0] BLEND_ONE_RST = 17'd32768;
  localparam logic [16:0] BLEND_TWO_RST = 17'd0;
  localparam logic [3:0]  VOICES_RST    = 4'd1;
  localparam logic [16:0] DETUNE_RST    = 17'd65536;

  typedef enum logic [1:0] {
    MODE_SYNC = 2'd0,
    MODE_FM   = 2'd1,
    MODE_AM   = 2'd2,
    MODE_OFF  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/unison_dual_osc_voice_core.sv */
// Unison dual-oscillator voice core: top level with voice pipeline and control.
// Depends on udov_pkg and udov_phase_store.
//
// One input item is one sample tick. The block takes one item at a time and runs
// its active voices (the voices register, at least one, at most MAX_VOICES) one per cycle
// through an eight-stage pipeline that reads both phases of a voice from the phase
// memory, advances them, writes them back and folds the voice into the stereo sums.
// An item with N active voices raises out_valid once its last voice has left the
// pipeline and the result has been loaded from the done state; the next item is
// taken only back in the idle state. The single read port of the phase memory (one
// voice per cycle) and the pipeline depth set how far apart items come. In the off
// mode no voice runs, and a zero result is loaded from the done state. The input is
// not taken while an item is in flight; a finished result may wait in the output
// register while the next item is accepted.
module unison_dual_osc_voice_core #(
  parameter int MAX_VOICES = udov_pkg::MAX_VOICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [udov_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [udov_pkg::CFG_W-1:0]     cfg_wdata,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [23:0]                    in_base_step,
  input  logic [15:0]                    in_pulse_width_one,
  input  logic [15:0]                    in_pulse_width_two,
  input  logic [18:0]                    in_pitch_ratio,
  input  logic [16:0]                    in_fm_depth,
  input  logic [16:0]                    in_mix_amount,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [18:0]             out_left_sum,
  output logic signed [18:0]             out_right_sum
);

  localparam int AW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW    = ($clog2(MAX_VOICES + 1) > 4) ? $clog2(MAX_VOICES + 1) : 4;
  localparam int PW    = udov_pkg::PHASE_W;
  localparam int SW    = udov_pkg::STEP_W;
  localparam int VW    = udov_pkg::VOICE_W;
  localparam int ACC_W = VW + $clog2(MAX_VOICES + 1);
  localparam int NST   = 8;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VOICES);
  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(udov_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] OUT_LO = ACC_W'(udov_pkg::OUT_MIN);

  // ---------------------------------------------------------------- config
  logic [16:0]     blend_one_r, blend_two_r, detune_r;
  logic [3:0]      voices_r;
  udov_pkg::mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_one_r <= udov_pkg::BLEND_ONE_RST;
      blend_two_r <= udov_pkg::BLEND_TWO_RST;
      mode_r      <= udov_pkg::MODE_SYNC;
      voices_r    <= udov_pkg::VOICES_RST;
      detune_r    <= udov_pkg::DETUNE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        udov_pkg::REG_BLEND_ONE: blend_one_r <= cfg_wdata;
        udov_pkg::REG_BLEND_TWO: blend_two_r <= cfg_wdata;
        udov_pkg::REG_OSC_MODE:  mode_r      <= udov_pkg::mode_t'(cfg_wdata[1:0]);
        udov_pkg::REG_VOICES:    voices_r    <= cfg_wdata[3:0];
        udov_pkg::REG_DETUNE:    detune_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [16:0] b1, b2;
  assign b1 = (blend_one_r > udov_pkg::BLEND_ONE) ? udov_pkg::BLEND_ONE : blend_one_r;
  assign b2 = (blend_two_r > udov_pkg::BLEND_ONE) ? udov_pkg::BLEND_ONE : blend_two_r;

  logic [CW-1:0] n_cfg;
  always_comb begin
    if (voices_r == 4'd0) begin
      n_cfg = CW'(1);
    end else if (CW'(voices_r) > MAX_CNT) begin
      n_cfg = MAX_CNT;
    end else begin
      n_cfg = CW'(voices_r);
    end
  end

  // ---------------------------------------------------------------- control
  udov_pkg::state_t state_r, state_nxt;
  logic             in_acc, issue, out_load, last_issue;
  logic [CW-1:0]    vidx_r, n_r;
  logic [NST:1]     vld_r, first_r, last_r;

  assign in_acc     = in_valid && !in_stall;
  assign last_issue = (vidx_r == n_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      udov_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = (mode_r == udov_pkg::MODE_OFF) ? udov_pkg::ST_DONE : udov_pkg::ST_RUN;
        end
      end
      udov_pkg::ST_RUN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_nxt = udov_pkg::ST_DRAIN;
        end
      end
      udov_pkg::ST_DRAIN: begin
        if (vld_r[NST] && last_r[NST]) begin
          state_nxt = udov_pkg::ST_DONE;
        end
      end
      udov_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = udov_pkg::ST_IDLE;
        end
      end
      default: state_nxt = udov_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udov_pkg::ST_IDLE;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= {vld_r[NST-1:1], issue};
    end
  end

  // ---------------------------------------------------------------- item setup
  logic [15:0]               pw1_r, pw2_r;
  logic [18:0]               pitch_r;
  logic [16:0]               mix_r;
  logic [udov_pkg::DM_W-1:0] dm_r;
  logic [SW-1:0]             step_r, step_nxt;
  logic [41:0]               det_prod;
  logic [25:0]               det_step;

  // Next voice step: voices 0 and 1 share the base step
  assign det_prod = 42'(step_r) * 42'(detune_r);
  assign det_step = det_prod[41:16];
  always_comb begin
    step_nxt = step_r;
    if (vidx_r != '0) begin
      step_nxt = det_step[25] ? {SW{1'b1}} : det_step[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pw1_r   <= in_pulse_width_one;
      pw2_r   <= in_pulse_width_two;
      pitch_r <= in_pitch_ratio;
      mix_r   <= in_mix_amount;
      dm_r    <= udov_pkg::DM_W'(in_fm_depth * udov_pkg::FM_SCALE);
      step_r  <= SW'(in_base_step);
      n_r     <= n_cfg;
      vidx_r  <= '0;
    end else if (issue) begin
      step_r <= step_nxt;
      vidx_r <= vidx_r + CW'(1);
    end
  end

  // ---------------------------------------------------------------- phase store
  logic [PW-1:0] rd_p1, rd_p2, np1, np2;
  logic [AW-1:0] s1_addr_r, s2_addr_r;

  udov_phase_store #(
    .DEPTH (MAX_VOICES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (vidx_r[AW-1:0]),
    .rd_p1   (rd_p1),
    .rd_p2   (rd_p2),
    .wr_en   (vld_r[2]),
    .wr_addr (s2_addr_r),
    .wr_p1   (np1),
    .wr_p2   (np2)
  );

  // ---------------------------------------------------------------- voice pipeline
  logic [SW-1:0]        s1_step_r, s2_step_r;
  logic [PW-1:0]        s2_p1_r, s2_p2_r;
  logic [43:0]          s2_p2prod_r;
  logic signed [55:0]   s2_fm_r;
  logic [PW-1:0]        s3_p1_r, s3_p2_r, s4_p1_r, s4_p2_r, s5_p1_r, s5_p2_r;
  logic signed [25:0]   s4_d1_r, s4_d2_r;
  logic signed [43:0]   s5_pr1_r, s5_pr2_r;
  logic signed [25:0]   s6_o1_r, s6_o2_r, s7_o1_r, s7_o2_r;
  logic [49:0]          s7_am_r;
  logic signed [43:0]   s7_mx_r;
  logic signed [25:0]   s8_base_r;
  logic signed [45:0]   s8_m2_r;

  // stage 1: multiplies for the second step and the FM offset
  logic signed [23:0] p2_ctr;
  logic signed [55:0] fm_prod;
  logic [43:0]        p2_prod;
  assign p2_ctr  = {~rd_p2[PW-1], rd_p2[PW-2:0]};  // phase two minus one half
  assign fm_prod = 56'(p2_ctr) * 56'($signed({1'b0, dm_r}));
  assign p2_prod = 44'(s1_step_r) * 44'(pitch_r);

  // stage 2: advance the phases
  logic [25:0]   sync_sum;
  logic [PW-1:0] p2_step, p2_adv;
  assign sync_sum = 26'(s2_p1_r) + 26'(s2_step_r);
  assign p2_step  = s2_p2prod_r[39:16];
  assign p2_adv   = s2_p2_r + p2_step;
  always_comb begin
    np1 = s2_p1_r + s2_step_r[PW-1:0];
    np2 = p2_adv;
    case (mode_r)
      udov_pkg::MODE_SYNC: begin
        np1 = sync_sum[PW-1:0];
        if (|sync_sum[25:24]) begin
          np2 = '0;
        end
      end
      udov_pkg::MODE_FM: np1 = s2_p1_r + s2_step_r[PW-1:0] + s2_fm_r[55:32];
      default: ;
    endcase
  end

  // stage 3: pulse and distance from the phase to it
  logic [24:0]        pls1_sum, pls2_sum;
  logic signed [25:0] d1, d2;
  assign pls1_sum = 25'(s3_p1_r) + {1'b0, pw1_r, 8'h00};
  assign pls2_sum = 25'(s3_p2_r) + {1'b0, pw2_r, 8'h00};
  assign d1 = $signed({1'b0, pls1_sum[24], 24'd0}) - $signed({2'b00, s3_p1_r});
  assign d2 = $signed({1'b0, pls2_sum[24], 24'd0}) - $signed({2'b00, s3_p2_r});

  // stage 4: blend products
  logic signed [43:0] pr1, pr2;
  assign pr1 = 44'($signed({1'b0, b1})) * 44'(s4_d1_r);
  assign pr2 = 44'($signed({1'b0, b2})) * 44'(s4_d2_r);

  // stage 5: shapes
  logic signed [25:0] o1, o2;
  assign o1 = $signed({2'b00, s5_p1_r}) + 26'(s5_pr1_r >>> 16);
  assign o2 = $signed({2'b00, s5_p2_r}) + 26'(s5_pr2_r >>> 16);

  // stage 6: ring product and mix product
  logic [49:0]        am_prod;
  logic signed [43:0] mx_prod;
  assign am_prod = 50'(s6_o1_r[24:0]) * 50'(s6_o2_r[24:0]);
  assign mx_prod = 44'($signed({1'b0, mix_r})) * 44'(s6_o2_r - s6_o1_r);

  // stage 7: AM amount, or pass the mix product
  logic signed [26:0] am_diff;
  logic signed [18:0] am_amt;
  logic signed [45:0] m2;
  logic signed [25:0] base;
  assign am_diff = $signed({1'b0, s7_am_r[49:24]}) - 27'(s7_o2_r);
  assign am_amt  = 19'sd65536 - $signed({2'b00, mix_r});
  always_comb begin
    if (mode_r == udov_pkg::MODE_AM) begin
      m2   = 46'(am_amt) * 46'(am_diff);
      base = s7_o2_r;
    end else begin
      m2   = 46'(s7_mx_r);
      base = s7_o1_r;
    end
  end

  // stage 8: voice value into the stereo sums
  logic signed [VW-1:0]    v;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  assign v = 28'(s8_base_r) + 28'(s8_m2_r >>> 16) - 28'sd8388608;

  always_ff @(posedge clk) begin
    first_r     <= {first_r[NST-1:1], vidx_r == '0};
    last_r      <= {last_r[NST-1:1], last_issue};
    s1_step_r   <= step_r;
    s1_addr_r   <= vidx_r[AW-1:0];
    s2_step_r   <= s1_step_r;
    s2_addr_r   <= s1_addr_r;
    s2_p1_r     <= rd_p1;
    s2_p2_r     <= rd_p2;
    s2_p2prod_r <= p2_prod;
    s2_fm_r     <= fm_prod;
    s3_p1_r     <= np1;
    s3_p2_r     <= np2;
    s4_p1_r     <= s3_p1_r;
    s4_p2_r     <= s3_p2_r;
    s4_d1_r     <= d1;
    s4_d2_r     <= d2;
    s5_p1_r     <= s4_p1_r;
    s5_p2_r     <= s4_p2_r;
    s5_pr1_r    <= pr1;
    s5_pr2_r    <= pr2;
    s6_o1_r     <= o1;
    s6_o2_r     <= o2;
    s7_o1_r     <= s6_o1_r;
    s7_o2_r     <= s6_o2_r;
    s7_am_r     <= am_prod;
    s7_mx_r     <= mx_prod;
    s8_base_r   <= base;
    s8_m2_r     <= m2;
  end

  // Voice 0 lands on both sides; later voices spread left plus, right minus
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (vld_r[NST]) begin
      if (first_r[NST]) begin
        acc_l_r <= ACC_W'(v);
        acc_r_r <= ACC_W'(v);
      end else begin
        acc_l_r <= acc_l_r + ACC_W'(v);
        acc_r_r <= acc_r_r - ACC_W'(v);
      end
    end
  end

  // ---------------------------------------------------------------- result
  logic signed [ACC_W-1:0] sh_l, sh_r;
  logic signed [18:0]      sat_l, sat_r;
  logic                    out_valid_r;
  logic signed [18:0]      out_left_r, out_right_r;

  assign sh_l = acc_l_r >>> 8;
  assign sh_r = acc_r_r >>> 8;
  always_comb begin
    if (sh_l > OUT_HI) begin
      sat_l = OUT_HI[18:0];
    end else if (sh_l < OUT_LO) begin
      sat_l = OUT_LO[18:0];
    end else begin
      sat_l = sh_l[18:0];
    end
    if (sh_r > OUT_HI) begin
      sat_r = OUT_HI[18:0];
    end else if (sh_r < OUT_LO) begin
      sat_r = OUT_LO[18:0];
    end else begin
      sat_r = sh_r[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= sat_l;
      out_right_r <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_sum  = out_left_r;
  assign out_right_sum = out_right_r;

  // ---------------------------------------------------------------- checks
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == udov_pkg::ST_DONE))
    else $error("result loaded outside of the done state");

  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (vld_r == '0))
    else $error("item accepted while voices are in flight");

  a_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (state_r == udov_pkg::ST_RUN || state_r == udov_pkg::ST_DRAIN))
    else $error("phase write outside of a running item");

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NST] && last_r[NST]) |-> (state_r == udov_pkg::ST_DRAIN))
    else $error("last voice retired outside of drain");

endmodule

/* rtl/core/udov_phase_store.sv */
// Phase memory of the voice core: both phases of every unison voice in one word.
// One write port, one registered read port; entries never written read as zero.
// Depends on udov_pkg.
module udov_phase_store #(
  parameter int DEPTH = udov_pkg::MAX_VOICES_DEF,
  parameter int AW    = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [AW-1:0]                rd_addr,
  output logic [udov_pkg::PHASE_W-1:0] rd_p1,
  output logic [udov_pkg::PHASE_W-1:0] rd_p2,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [udov_pkg::PHASE_W-1:0] wr_p1,
  input  logic [udov_pkg::PHASE_W-1:0] wr_p2
);

  logic [2*udov_pkg::PHASE_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]               ok_r;
  logic [2*udov_pkg::PHASE_W-1:0] rd_word_r;
  logic                           rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_p2, wr_p1};
    end
    rd_word_r <= mem_r[rd_addr];
  end

  // Valid bits stand in for the zero reset of the phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r    <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        ok_r[wr_addr] <= 1'b1;
      end
      rd_ok_r <= ok_r[rd_addr];
    end
  end

  assign rd_p1 = rd_ok_r ? rd_word_r[udov_pkg::PHASE_W-1:0] : '0;
  assign rd_p2 = rd_ok_r ? rd_word_r[2*udov_pkg::PHASE_W-1:udov_pkg::PHASE_W] : '0;

endmodule
